>>> hw/rtl/sha_pkg.sv
// SHA-256 hasher package: sizes, initial hash values, round constants
// and the round functions. Used by sha256_stream_hasher and sha_checker.
package sha_pkg;

    localparam int BLOCK_BYTES  = 64;
    localparam int FILL_W       = $clog2(BLOCK_BYTES);
    localparam int CNT_W        = FILL_W + 1;
    localparam int LEN_POS      = 56;
    localparam int NUM_HASH     = 8;
    localparam int HIDX_W       = $clog2(NUM_HASH);
    localparam int NUM_ROUNDS   = 64;
    localparam int WIN_WORDS    = 16;
    localparam int DUE_W        = 5;

    localparam logic [7:0]        PAD_MARK = 8'h80;
    localparam logic [HIDX_W-1:0] LAST_IDX = HIDX_W'(NUM_HASH - 1);

    typedef logic [31:0] t_word;

    localparam t_word INIT_HASH [NUM_HASH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

>>> hw/rtl/sha_if.sv
// Valid/ready channel interfaces of the SHA-256 hasher: byte requests in,
// digest words out. No dependencies.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hw/rtl/sha_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream; uses sha_pkg, sha_if and sha_ram.
// Byte requests are accepted only in the idle state, not while a block is processed.
// Each full block is loaded through the single read port of the block RAM, compressed
// one round per cycle and written back to the hash RAM. A message end adds up to 72
// padding writes, one or two block compressions, and a read and a load per digest word.
// Reset (synchronous, active low) restores the initial hash values and clears counts.
module sha256_stream_hasher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     i_in,
    sha_out_if.source  o_out
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_OUT_RD = 3'd5;
    localparam logic [2:0] S_OUT_LD = 3'd6;

    // Control registers.
    logic [2:0]          r_state,  n_state;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [63:0]         r_bits,   n_bits;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic                r_msg_end, n_msg_end;
    logic                r_mark,   n_mark;
    logic                r_lenblk, n_lenblk;
    logic [NUM_HASH-1:0] r_hvalid, n_hvalid;
    logic [HIDX_W-1:0]   r_k,      n_k;
    logic                r_ovalid, n_ovalid;

    // Datapath registers.
    t_word               r_w [WIN_WORDS];
    t_word               r_v [NUM_HASH];
    logic                r_hsel;
    logic [HIDX_W-1:0]   r_haddr_q;
    t_word               r_oword;
    logic [HIDX_W-1:0]   r_oidx;
    logic                r_olast;

    // Memory ports.
    logic                b_we, b_re;
    logic [FILL_W-1:0]   b_raddr;
    logic [7:0]          b_wdata, b_q;
    logic                h_we, h_re;
    logic [HIDX_W-1:0]   h_waddr, h_raddr;
    t_word               h_wdata, h_q, h_eff;

    logic                in_acc, out_acc;
    logic [7:0]          len_byte;
    logic                load_shift, hash_shift;
    t_word               t1, t2, w_new;

    sha_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_fill),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_q)
    );

    sha_ram #(.WIDTH(32), .DEPTH(NUM_HASH)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_q)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign in_acc            = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_oword;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = r_olast;
    assign out_acc           = r_ovalid && o_out.ready;

    // A hash entry not written since the last restart reads as its initial value.
    assign h_eff    = r_hsel ? h_q : INIT_HASH[r_haddr_q];
    assign len_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];

    assign load_shift = (r_state == S_LOAD) && (r_cnt != '0);
    assign hash_shift = load_shift && (r_cnt <= CNT_W'(NUM_HASH));

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + choose(r_v[4], r_v[5], r_v[6])
              + ROUND_K[r_cnt[FILL_W-1:0]] + r_w[0];
    assign t2 = big_sigma0(r_v[0]) + majority(r_v[0], r_v[1], r_v[2]);
    assign w_new = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_cnt     = r_cnt;
        n_msg_end = r_msg_end;
        n_mark    = r_mark;
        n_lenblk  = r_lenblk;
        n_hvalid  = r_hvalid;
        n_k       = r_k;
        n_ovalid  = out_acc ? 1'b0 : r_ovalid;
        b_we      = 1'b0;
        b_wdata   = i_in.data_byte;
        b_re      = 1'b0;
        b_raddr   = r_cnt[FILL_W-1:0];
        h_we      = 1'b0;
        h_waddr   = r_cnt[HIDX_W-1:0] - HIDX_W'(1);
        h_wdata   = h_eff + r_v[0];
        h_re      = 1'b0;
        h_raddr   = r_cnt[HIDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present) begin
                        b_we   = 1'b1;
                        n_fill = r_fill + FILL_W'(1);
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_in.message_end) begin
                        n_msg_end = 1'b1;
                        n_mark    = 1'b1;
                        n_lenblk  = 1'b0;
                    end
                    if (i_in.byte_present && (r_fill == FILL_W'(BLOCK_BYTES - 1))) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                    end else if (i_in.message_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                b_we = 1'b1;
                if (r_mark) begin
                    b_wdata  = PAD_MARK;
                    n_mark   = 1'b0;
                    // The length fits behind the mark only if the mark sits below it.
                    n_lenblk = (r_fill < FILL_W'(LEN_POS));
                end else if (r_lenblk && (r_fill >= FILL_W'(LEN_POS))) begin
                    b_wdata = len_byte;
                end else begin
                    b_wdata = 8'h00;
                end
                n_fill = r_fill + FILL_W'(1);
                if (r_fill == FILL_W'(BLOCK_BYTES - 1)) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                end
            end
            S_LOAD: begin
                b_re  = ~r_cnt[CNT_W-1];
                h_re  = (r_cnt < CNT_W'(NUM_HASH));
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BLOCK_BYTES)) begin
                    n_state = S_ROUND;
                    n_cnt   = '0;
                end
            end
            S_ROUND: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_ROUNDS - 1)) begin
                    n_state = S_FINAL;
                    n_cnt   = '0;
                end
            end
            S_FINAL: begin
                // Read entry cnt while entry cnt-1 is written back; never the same entry.
                h_re  = (r_cnt < CNT_W'(NUM_HASH));
                h_we  = (r_cnt != '0);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    n_hvalid[h_waddr] = 1'b1;
                end
                if (r_cnt == CNT_W'(NUM_HASH)) begin
                    if (!r_msg_end) begin
                        n_state = S_IDLE;
                    end else if (r_mark) begin
                        n_state = S_PAD;
                    end else if (r_lenblk) begin
                        n_state = S_OUT_RD;
                        n_k     = '0;
                    end else begin
                        n_lenblk = 1'b1;
                        n_state  = S_PAD;
                    end
                end
            end
            S_OUT_RD: begin
                h_raddr = r_k;
                if (!r_ovalid) begin
                    h_re    = 1'b1;
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                n_ovalid = 1'b1;
                n_k      = r_k + HIDX_W'(1);
                if (r_k == LAST_IDX) begin
                    n_hvalid  = '0;
                    n_bits    = '0;
                    n_msg_end = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_cnt     <= '0;
            r_msg_end <= 1'b0;
            r_mark    <= 1'b0;
            r_lenblk  <= 1'b0;
            r_hvalid  <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_cnt     <= n_cnt;
            r_msg_end <= n_msg_end;
            r_mark    <= n_mark;
            r_lenblk  <= n_lenblk;
            r_hvalid  <= n_hvalid;
            r_k       <= n_k;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_re) begin
            r_hsel    <= r_hvalid[h_raddr];
            r_haddr_q <= h_raddr;
        end
        // Bytes stream into the schedule window; byte 0 ends up in the top of word 0.
        if (load_shift) begin
            for (int j = 0; j < WIN_WORDS - 1; j++) begin
                r_w[j] <= {r_w[j][23:0], r_w[j+1][31:24]};
            end
            r_w[WIN_WORDS-1] <= {r_w[WIN_WORDS-1][23:0], b_q};
        end
        if (hash_shift || ((r_state == S_FINAL) && (r_cnt != '0))) begin
            for (int j = 0; j < NUM_HASH - 1; j++) begin
                r_v[j] <= r_v[j+1];
            end
            r_v[NUM_HASH-1] <= h_eff;
        end
        if (r_state == S_ROUND) begin
            for (int j = 0; j < WIN_WORDS - 1; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[WIN_WORDS-1] <= w_new;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if (r_state == S_OUT_LD) begin
            r_oword <= h_eff;
            r_oidx  <= r_k;
            r_olast <= (r_k == LAST_IDX);
        end
    end
endmodule

>>> hw/rtl/sha_checker.sv
// Port-level checker for the SHA-256 hasher and its bind statement.
// Depends on sha_pkg and on the ports of sha256_stream_hasher.
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_end,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic [2:0]  i_out_idx,
    input logic        i_out_last
);
    import sha_pkg::*;

    logic [DUE_W-1:0]  r_due;
    logic [HIDX_W-1:0] r_exp_idx;
    logic              in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Digest words still owed to the sink, and the index the next one must carry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due     <= '0;
            r_exp_idx <= '0;
        end else begin
            r_due <= r_due + ((in_acc && i_in_end) ? DUE_W'(NUM_HASH) : DUE_W'(0))
                           - (out_acc ? DUE_W'(1) : DUE_W'(0));
            if (out_acc) begin
                r_exp_idx <= r_exp_idx + HIDX_W'(1);
            end
        end
    end

    a_words_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_idx == r_exp_idx) && (i_out_last == (i_out_idx == LAST_IDX)))
        else $error("digest word out of sequence");

    a_no_unrequested_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_due != '0))
        else $error("digest word without a closed message");

    a_ready_only_near_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> (r_due == DUE_W'(0)) || (r_due == DUE_W'(1)))
        else $error("new request taken while a digest is still being produced");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_word))
        else $error("stalled digest word changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_end    (i_in.message_end),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.digest_word),
    .i_out_idx   (o_out.word_index),
    .i_out_last  (o_out.last_word)
);
